>>> rtl/rlc_pkg.sv
// Types, constants and shared functions of the rectangle line clipper.
package rlc_pkg;

  localparam int COORD_W    = 31;
  localparam int WIDE_W     = 64;
  localparam int DIFF_W     = 32;
  localparam int REG_IDX_W  = 2;
  localparam int NUM_STEPS  = 4;
  // Quotient bits resolved by the divider, one per stage
  localparam int DIV_BITS   = 63;
  // Divider registers: sign stage, one stage per bit, result stage
  localparam int DIV_STAGES = DIV_BITS + 2;
  // One clip step: setup, multiply, divide, update
  localparam int STEP_LAT   = DIV_STAGES + 3;
  // Edges from the edge that takes a segment to the edge that takes its result
  localparam int LATENCY    = NUM_STEPS * STEP_LAT + 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [DIV_BITS-1:0]       mag_t;
  typedef logic [3:0]                ocode_t;

  localparam ocode_t OC_LEFT  = 4'h1;
  localparam ocode_t OC_RIGHT = 4'h2;
  localparam ocode_t OC_BELOW = 4'h4;
  localparam ocode_t OC_ABOVE = 4'h8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_idx_e;

  localparam coord_t X_LOW_RST  = 31'sd0;
  localparam coord_t X_HIGH_RST = 31'sd262144;
  localparam coord_t Y_LOW_RST  = 31'sd0;
  localparam coord_t Y_HIGH_RST = 31'sd262144;

  // Segment state carried down the pipeline
  typedef struct packed {
    logic   ok;      // still visible
    logic   act;     // current pass clips a point
    logic   two;     // both endpoints start outside
    logic   b_end;   // the point being moved is the end point
    ocode_t code;    // outcode of the point being moved
    ocode_t code_s;  // original outcode of the start point
    wide_t  sx;
    wide_t  sy;
    wide_t  ex;
    wide_t  ey;
  } seg_t;

  // Segment state plus what one clip step decided
  typedef struct packed {
    seg_t   seg;
    logic   need;
    coord_t clip_edge;
  } step_t;

  function automatic ocode_t outcode(input coord_t x, input coord_t y,
                                     input coord_t xl, input coord_t xh,
                                     input coord_t yl, input coord_t yh);
    ocode_t c;
    c = '0;
    if (x < xl) begin
      c = c | OC_LEFT;
    end else if (x > xh) begin
      c = c | OC_RIGHT;
    end
    if (y < yl) begin
      c = c | OC_BELOW;
    end else if (y > yh) begin
      c = c | OC_ABOVE;
    end
    return c;
  endfunction

endpackage

>>> rtl/rect_line_clipper.sv
// Outcode line clipper against a configured rectangle, one segment per cycle.
// Takes a segment in every cycle; busy stays low and cfg_ready_o stays high.
// A result passes through four clip
// steps of 68 stages each (65 of them in the divider) plus entry, mid-check and output.
// Reset clears all valid bits and loads the default rectangle; data is not reset.
// The receiver cannot stall, so every result shows for exactly one cycle.
module rect_line_clipper (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  rlc_pkg::coord_t                    start_x_i,
  input  rlc_pkg::coord_t                    start_y_i,
  input  rlc_pkg::coord_t                    end_x_i,
  input  rlc_pkg::coord_t                    end_y_i,
  output logic                               result_valid_o,
  output logic                               visible_o,
  output rlc_pkg::coord_t                    clipped_start_x_o,
  output rlc_pkg::coord_t                    clipped_start_y_o,
  output rlc_pkg::coord_t                    clipped_end_x_o,
  output rlc_pkg::coord_t                    clipped_end_y_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rlc_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  rlc_pkg::coord_t                    cfg_data_i
);
  import rlc_pkg::*;

  localparam coord_t CoordMin = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t CoordMax = {1'b0, {(COORD_W-1){1'b1}}};

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v < wide_t'(CoordMin)) begin
      r = CoordMin;
    end else if (v > wide_t'(CoordMax)) begin
      r = CoordMax;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  coord_t x_low_q, x_high_q, y_low_q, y_high_q;
  logic   in_acc;
  ocode_t cs, ce;
  seg_t   ent_d, ent_q;
  logic   ent_v_q;
  seg_t   mid_d, mid_q;
  logic   mid_v_q;
  logic   mid_ok;
  seg_t   pst_seg [NUM_STEPS];
  logic   pst_v   [NUM_STEPS];
  seg_t   fin;
  logic   res_v_q, vis_q;
  coord_t csx_q, csy_q, cex_q, cey_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = start && !busy;

  // Write the rectangle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= X_LOW_RST;
      x_high_q <= X_HIGH_RST;
      y_low_q  <= Y_LOW_RST;
      y_high_q <= Y_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_X_LOW:  x_low_q  <= cfg_data_i;
        REG_X_HIGH: x_high_q <= cfg_data_i;
        REG_Y_LOW:  y_low_q  <= cfg_data_i;
        REG_Y_HIGH: y_high_q <= cfg_data_i;
        default:    x_low_q  <= x_low_q;
      endcase
    end
  end

  // Classify the segment by its two outcodes
  always_comb begin
    cs           = outcode(start_x_i, start_y_i, x_low_q, x_high_q, y_low_q, y_high_q);
    ce           = outcode(end_x_i, end_y_i, x_low_q, x_high_q, y_low_q, y_high_q);
    ent_d        = '0;
    ent_d.sx     = wide_t'(start_x_i);
    ent_d.sy     = wide_t'(start_y_i);
    ent_d.ex     = wide_t'(end_x_i);
    ent_d.ey     = wide_t'(end_y_i);
    ent_d.code_s = cs;
    priority if ((cs | ce) == '0) begin
      ent_d.ok = 1'b1;
    end else if (cs == '0) begin
      ent_d.ok    = 1'b1;
      ent_d.act   = 1'b1;
      ent_d.b_end = 1'b1;
      ent_d.code  = ce;
    end else if (ce == '0) begin
      ent_d.ok   = 1'b1;
      ent_d.act  = 1'b1;
      ent_d.code = cs;
    end else if ((cs & ce) != '0) begin
      ent_d.ok = 1'b0;
    end else begin
      ent_d.ok    = 1'b1;
      ent_d.act   = 1'b1;
      ent_d.two   = 1'b1;
      ent_d.b_end = 1'b1;
      ent_d.code  = ce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else begin
      ent_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // Clip steps: Y then X for the first point, Y then X for the second
  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    localparam bit AxisX = (k % 2) == 1;

    seg_t   in_seg;
    logic   in_v;
    seg_t   su_d;
    wide_t  ax, ay, bx, by, ap, ao, bp, bo;
    wide_t  x_lo, x_hi, edge_w, dop, dpe, dpp;
    logic   need;
    coord_t clip_edge;
    logic   su_v_q;
    step_t  su_q;
    diff_t  ma_q, mb_q;
    wide_t  sdv_q;
    logic   mu_v_q;
    step_t  mu_q;
    wide_t  prod_q, mdv_q;
    logic   dv_v;
    wide_t  quo;
    step_t  dinf;
    seg_t   po_d;
    wide_t  pax, pay, pao, nbo, pedge;
    logic   po_v_q;
    seg_t   po_q;

    if (k == 0) begin : g_src_entry
      assign in_seg = ent_q;
      assign in_v   = ent_v_q;
    end else if (k == 2) begin : g_src_mid
      assign in_seg = mid_q;
      assign in_v   = mid_v_q;
    end else begin : g_src_prev
      assign in_seg = pst_seg[k-1];
      assign in_v   = pst_v[k-1];
    end

    // Decide the edge and form the interpolation operands
    always_comb begin
      su_d = in_seg;
      ax   = in_seg.b_end ? in_seg.sx : in_seg.ex;
      ay   = in_seg.b_end ? in_seg.sy : in_seg.ey;
      bx   = in_seg.b_end ? in_seg.ex : in_seg.sx;
      by   = in_seg.b_end ? in_seg.ey : in_seg.sy;
      ap   = AxisX ? ax : ay;
      ao   = AxisX ? ay : ax;
      bp   = AxisX ? bx : by;
      bo   = AxisX ? by : bx;
      x_lo = wide_t'(x_low_q);
      x_hi = wide_t'(x_high_q);
      if (AxisX) begin
        need      = in_seg.act && in_seg.ok && ((bx < x_lo) || (bx > x_hi));
        clip_edge = (bx < x_lo) ? x_low_q : x_high_q;
      end else begin
        need      = in_seg.act && in_seg.ok && ((in_seg.code & (OC_ABOVE | OC_BELOW)) != '0);
        clip_edge = ((in_seg.code & OC_ABOVE) != '0) ? y_high_q : y_low_q;
      end
      // Drop a segment with no span along the clip axis
      if (need && (ap == bp)) begin
        su_d.ok = 1'b0;
        need    = 1'b0;
      end
      edge_w = wide_t'(clip_edge);
      dop    = bo - ao;
      dpe    = ap - edge_w;
      dpp    = ap - bp;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        su_v_q <= 1'b0;
        mu_v_q <= 1'b0;
        po_v_q <= 1'b0;
      end else begin
        su_v_q <= in_v;
        mu_v_q <= su_v_q;
        po_v_q <= dv_v;
      end
    end

    // Hold operands, then multiply
    always_ff @(posedge clk_i) begin
      su_q.seg       <= su_d;
      su_q.need      <= need;
      su_q.clip_edge <= clip_edge;
      ma_q           <= dop[DIFF_W-1:0];
      mb_q           <= dpe[DIFF_W-1:0];
      sdv_q          <= dpp;
      mu_q           <= su_q;
      prod_q         <= ma_q * mb_q;
      mdv_q          <= sdv_q;
    end

    rlc_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (mu_v_q),
      .dividend_i (prod_q),
      .divisor_i  (mdv_q),
      .info_i     (mu_q),
      .valid_o    (dv_v),
      .quotient_o (quo),
      .info_o     (dinf)
    );

    // Move the point onto the edge
    always_comb begin
      po_d  = dinf.seg;
      pax   = po_d.b_end ? po_d.sx : po_d.ex;
      pay   = po_d.b_end ? po_d.sy : po_d.ey;
      pao   = AxisX ? pay : pax;
      nbo   = pao + quo;
      pedge = wide_t'(dinf.clip_edge);
      if (dinf.need) begin
        if (po_d.b_end) begin
          if (AxisX) begin
            po_d.ex = pedge;
            po_d.ey = nbo;
          end else begin
            po_d.ey = pedge;
            po_d.ex = nbo;
          end
        end else begin
          if (AxisX) begin
            po_d.sx = pedge;
            po_d.sy = nbo;
          end else begin
            po_d.sy = pedge;
            po_d.sx = nbo;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      po_q <= po_d;
    end

    assign pst_seg[k] = po_q;
    assign pst_v[k]   = po_v_q;
  end

  // Check the clipped end point, then set up the start point pass
  always_comb begin
    mid_d  = pst_seg[1];
    mid_ok = mid_d.ok && (mid_d.ey >= wide_t'(y_low_q)) && (mid_d.ey <= wide_t'(y_high_q));
    if (mid_d.two) begin
      mid_d.ok    = mid_ok;
      mid_d.act   = mid_ok;
      mid_d.b_end = 1'b0;
      mid_d.code  = mid_d.code_s;
    end else begin
      mid_d.act = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      mid_v_q <= pst_v[1];
      res_v_q <= pst_v[3];
    end
  end

  // Zero a rejected segment, saturate a visible one
  assign fin = pst_seg[3];

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    vis_q <= fin.ok;
    csx_q <= fin.ok ? sat_coord(fin.sx) : '0;
    csy_q <= fin.ok ? sat_coord(fin.sy) : '0;
    cex_q <= fin.ok ? sat_coord(fin.ex) : '0;
    cey_q <= fin.ok ? sat_coord(fin.ey) : '0;
  end

  assign result_valid_o    = res_v_q;
  assign visible_o         = vis_q;
  assign clipped_start_x_o = csx_q;
  assign clipped_start_y_o = csy_q;
  assign clipped_end_x_o   = cex_q;
  assign clipped_end_y_o   = cey_q;

endmodule

>>> rtl/rlc_div.sv
// Pipelined signed divider, truncating toward zero, with a sideband beat.
module rlc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rlc_pkg::wide_t dividend_i,
  input  rlc_pkg::wide_t divisor_i,
  input  rlc_pkg::step_t info_i,
  output logic           valid_o,
  output rlc_pkg::wide_t quotient_o,
  output rlc_pkg::step_t info_o
);
  import rlc_pkg::*;

  logic [DIV_BITS:0]   v_q;
  mag_t                rem_d [DIV_BITS+1];
  mag_t                rem_q [DIV_BITS+1];
  mag_t                nq_d  [DIV_BITS+1];
  mag_t                nq_q  [DIV_BITS+1];
  mag_t                den_d [DIV_BITS+1];
  mag_t                den_q [DIV_BITS+1];
  logic                neg_d [DIV_BITS+1];
  logic                neg_q [DIV_BITS+1];
  step_t               inf_d [DIV_BITS+1];
  step_t               inf_q [DIV_BITS+1];
  wide_t               n_abs;
  wide_t               d_abs;
  wide_t               q_pos;
  logic [DIV_BITS:0]   sh;
  logic [DIV_BITS+1:0] df;
  logic                out_v_q;
  wide_t               quot_q;
  step_t               info_q;

  // Take magnitudes, then resolve one quotient bit per stage
  always_comb begin
    n_abs    = dividend_i[WIDE_W-1] ? -dividend_i : dividend_i;
    d_abs    = divisor_i[WIDE_W-1] ? -divisor_i : divisor_i;
    rem_d[0] = '0;
    nq_d[0]  = n_abs[DIV_BITS-1:0];
    den_d[0] = d_abs[DIV_BITS-1:0];
    neg_d[0] = dividend_i[WIDE_W-1] ^ divisor_i[WIDE_W-1];
    inf_d[0] = info_i;
    sh       = '0;
    df       = '0;
    for (int i = 1; i <= DIV_BITS; i++) begin
      sh = {rem_q[i-1], nq_q[i-1][DIV_BITS-1]};
      df = {1'b0, sh} - {2'b00, den_q[i-1]};
      if (df[DIV_BITS+1]) begin
        rem_d[i] = sh[DIV_BITS-1:0];
      end else begin
        rem_d[i] = df[DIV_BITS-1:0];
      end
      nq_d[i]  = {nq_q[i-1][DIV_BITS-2:0], !df[DIV_BITS+1]};
      den_d[i] = den_q[i-1];
      neg_d[i] = neg_q[i-1];
      inf_d[i] = inf_q[i-1];
    end
    q_pos = {1'b0, nq_q[DIV_BITS]};
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= {v_q[DIV_BITS-1:0], valid_i};
      out_v_q <= v_q[DIV_BITS];
    end
  end

  // Advance the data and apply the quotient sign
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    nq_q   <= nq_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    inf_q  <= inf_d;
    quot_q <= neg_q[DIV_BITS] ? -q_pos : q_pos;
    info_q <= inf_q[DIV_BITS];
  end

  assign valid_o    = out_v_q;
  assign quotient_o = quot_q;
  assign info_o     = info_q;

endmodule

>>> rtl/rlc_check.sv
// Port-level checks of the line clipper and their binding to the top level.
module rlc_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input rlc_pkg::coord_t               start_x_i,
  input rlc_pkg::coord_t               start_y_i,
  input rlc_pkg::coord_t               end_x_i,
  input rlc_pkg::coord_t               end_y_i,
  input logic                          result_valid_o,
  input logic                          visible_o,
  input rlc_pkg::coord_t               clipped_start_x_o,
  input rlc_pkg::coord_t               clipped_start_y_o,
  input rlc_pkg::coord_t               clipped_end_x_o,
  input rlc_pkg::coord_t               clipped_end_y_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [rlc_pkg::REG_IDX_W-1:0] cfg_index_i,
  input rlc_pkg::coord_t               cfg_data_i
);
  import rlc_pkg::*;

  coord_t xl_q, xh_q, yl_q, yh_q;
  logic   in_acc;
  logic   seg_in_rect;

  // Track the rectangle from configuration beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xl_q <= X_LOW_RST;
      xh_q <= X_HIGH_RST;
      yl_q <= Y_LOW_RST;
      yh_q <= Y_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_X_LOW:  xl_q <= cfg_data_i;
        REG_X_HIGH: xh_q <= cfg_data_i;
        REG_Y_LOW:  yl_q <= cfg_data_i;
        REG_Y_HIGH: yh_q <= cfg_data_i;
        default:    xl_q <= xl_q;
      endcase
    end
  end

  assign in_acc = start && !busy;
  assign seg_in_rect = in_acc
      && (outcode(start_x_i, start_y_i, xl_q, xh_q, yl_q, yh_q) == '0)
      && (outcode(end_x_i, end_y_i, xl_q, xh_q, yl_q, yh_q) == '0);

  // A rejected segment reports all coordinates as zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !visible_o) |->
      (clipped_start_x_o == '0 && clipped_start_y_o == '0 &&
       clipped_end_x_o == '0 && clipped_end_y_o == '0))
    else $error("rejected segment with nonzero coordinates");

  // Every result traces back to a segment taken a fixed time earlier
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching segment");

  // A segment fully in the rectangle comes out unchanged and visible
  a_inside_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_in_rect |-> ##LATENCY (result_valid_o && visible_o &&
      clipped_start_x_o == $past(start_x_i, LATENCY) &&
      clipped_start_y_o == $past(start_y_i, LATENCY) &&
      clipped_end_x_o == $past(end_x_i, LATENCY) &&
      clipped_end_y_o == $past(end_y_i, LATENCY)))
    else $error("inside segment not passed unchanged");

endmodule

bind rect_line_clipper rlc_check u_rlc_check (.*);

>>> bench/tb.sv
// Self-checking bench for the rectangle line clipper: scoreboard, stimulus and top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlc_pkg::*;

  localparam longint CMIN = -1073741824;
  localparam longint CMAX = 1073741823;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    bit     vis;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_res_t;

  // Expected clip results and the rectangle they are computed against
  class clip_scoreboard;
    clip_res_t pending[$];
    int        errors;
    longint    xl, xh, yl, yh;

    function new();
      errors = 0;
      xl = X_LOW_RST;
      xh = X_HIGH_RST;
      yl = Y_LOW_RST;
      yh = Y_HIGH_RST;
    endfunction

    function void set_edge(reg_idx_e idx, coord_t val);
      case (idx)
        REG_X_LOW:  xl = val;
        REG_X_HIGH: xh = val;
        REG_Y_LOW:  yl = val;
        REG_Y_HIGH: yh = val;
        default: ;
      endcase
    endfunction

    function ocode_t region(longint x, longint y);
      ocode_t c;
      c = '0;
      if (x < xl) c |= OC_LEFT;
      else if (x > xh) c |= OC_RIGHT;
      if (y < yl) c |= OC_BELOW;
      else if (y > yh) c |= OC_ABOVE;
      return c;
    endfunction

    // Move point b toward anchor a onto the edges its code names
    function bit move_point(longint ax, longint ay, ref longint bx, ref longint by,
                            input ocode_t c);
      longint e;
      if (c & (OC_ABOVE | OC_BELOW)) begin
        e = (c & OC_ABOVE) ? yh : yl;
        if (ay == by) return 0;
        bx = ax + ((bx - ax) * (ay - e)) / (ay - by);
        by = e;
      end
      if (bx < xl || bx > xh) begin
        e = (bx < xl) ? xl : xh;
        if (ax == bx) return 0;
        by = ay + ((by - ay) * (ax - e)) / (ax - bx);
        bx = e;
      end
      return 1;
    endfunction

    function coord_t sat(longint v);
      if (v < CMIN) v = CMIN;
      if (v > CMAX) v = CMAX;
      return coord_t'(v);
    endfunction

    function void note_segment(coord_t isx, coord_t isy, coord_t iex, coord_t iey);
      longint    sx, sy, ex, ey;
      ocode_t    cs, ce;
      bit        ok;
      clip_res_t r;
      sx = isx; sy = isy; ex = iex; ey = iey;
      cs = region(sx, sy);
      ce = region(ex, ey);
      ok = 1;
      if ((cs | ce) == 0) ok = 1;
      else if (cs == 0) ok = move_point(sx, sy, ex, ey, ce);
      else if (ce == 0) ok = move_point(ex, ey, sx, sy, cs);
      else if ((cs & ce) != 0) ok = 0;
      else begin
        ok = move_point(sx, sy, ex, ey, ce);
        if (ok && (ey < yl || ey > yh)) ok = 0;
        if (ok) ok = move_point(ex, ey, sx, sy, cs);
      end
      if (!ok) begin
        sx = 0; sy = 0; ex = 0; ey = 0;
      end
      r.vis = ok;
      r.sx = sat(sx); r.sy = sat(sy); r.ex = sat(ex); r.ey = sat(ey);
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(bit vis, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      clip_res_t r;
      if (pending.size() == 0) begin
        report("result with no segment outstanding");
        return;
      end
      r = pending.pop_front();
      if (vis != r.vis) report($sformatf("visible %0d exp %0d", vis, r.vis));
      if (sx != r.sx) report($sformatf("start_x %0d exp %0d", sx, r.sx));
      if (sy != r.sy) report($sformatf("start_y %0d exp %0d", sy, r.sy));
      if (ex != r.ex) report($sformatf("end_x %0d exp %0d", ex, r.ex));
      if (ey != r.ey) report($sformatf("end_y %0d exp %0d", ey, r.ey));
    endtask
  endclass

  logic   clk_i = 0;
  logic   rst_ni = 0;
  logic   start = 0;
  logic   busy;
  coord_t start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic   result_valid_o, visible_o;
  coord_t clipped_start_x_o, clipped_start_y_o, clipped_end_x_o, clipped_end_y_o;
  logic   cfg_valid_i = 0;
  logic   cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  coord_t cfg_data_i = '0;

  clip_scoreboard sb = new();
  int  burst_left = 0;
  bit  calm = 0;
  int  idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  rect_line_clipper dut (.*);

  // Monitor beats on all three channels at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_edge(reg_idx_e'(cfg_index_i), cfg_data_i);
      if (start && !busy) sb.note_segment(start_x_i, start_y_i, end_x_i, end_y_i);
      if (result_valid_o)
        sb.check_result(visible_o, clipped_start_x_o, clipped_start_y_o,
                        clipped_end_x_o, clipped_end_y_o);
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rect_line_clipper verification failed");
        $finish;
      end
    end
  end

  // Load a whole rectangle, one beat per register
  task write_rect(longint xl, longint xh, longint yl, longint yh);
    longint v[4];
    v = '{xl, xh, yl, yh};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i  <= coord_t'(v[i]);
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 0;
  endtask

  // Offer one segment; insert a random gap between bursts unless calm is set
  task send_seg(longint sx, longint sy, longint ex, longint ey);
    if (burst_left == 0) begin
      if (!calm) begin
        start <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    start     <= 1;
    start_x_i <= coord_t'(sx);
    start_y_i <= coord_t'(sy);
    end_x_i   <= coord_t'(ex);
    end_y_i   <= coord_t'(ey);
    do @(posedge clk_i); while (busy);
    burst_left--;
  endtask

  // Hold off until every outstanding result has come back
  task drain();
    start <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function longint clampc(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  // Coordinate biased around an edge pair, sometimes exact edges, one past them, or full range
  function longint pick(longint lo, longint hi);
    longint span, off;
    int     m;
    m = $urandom_range(0, 9);
    if (m < 2) return longint'(coord_t'($urandom));
    if (m < 4) begin
      case ($urandom_range(0, 3))
        0: return clampc(lo);
        1: return clampc(hi);
        2: return clampc(lo - 1);
        default: return clampc(hi + 1);
      endcase
    end
    span = (hi > lo) ? hi - lo : lo - hi;
    span += 16;
    off = longint'({$urandom, $urandom} % (3 * span + 1));
    return clampc(((lo < hi) ? lo : hi) - span + off);
  endfunction

  task random_phase(int n);
    longint xl, xh, yl, yh;
    xl = sb.xl; xh = sb.xh; yl = sb.yl; yh = sb.yh;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 40);
      send_seg(pick(xl, xh), pick(yl, yh), pick(xl, xh), pick(yl, yh));
    end
    calm = 0;
    drain();
  endtask

  initial begin
    longint a, b;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed cases on the reset rectangle [0, 262144]^2
    send_seg(1000, 2000, 3000, 4000);               // fully inside
    send_seg(0, 0, 262144, 262144);                  // on the corners
    send_seg(-500, 10, -100, 200000);                // both left
    send_seg(300000, 10, 400000, 20);                // both right
    send_seg(10, -5, 200, -900);                     // both below
    send_seg(10, 300000, 20, 270000);                // both above
    send_seg(1000, 1000, 1000, 400000);              // end above
    send_seg(1000, 1000, 1000, -400000);             // end below
    send_seg(1000, 1000, -3000, 1200);               // end left
    send_seg(1000, 1000, 400000, 1300);              // end right
    send_seg(-7000, 300000, 5000, 5000);             // start corner region
    send_seg(-1000, 500, 300000, 700);               // both out, through
    send_seg(-1000, -1000, 300000, 300000);          // diagonal through
    send_seg(-1000, 300000, 1000, 600000);           // both out, shared above code
    send_seg(-100, 270000, 270000, -100);            // mid-check region
    send_seg(-40000, 1000, 300000, -200000);         // misses a corner
    send_seg(CMIN, CMIN, CMAX, CMAX);                // extreme diagonal
    send_seg(CMAX, CMIN, CMIN, CMAX);
    send_seg(CMIN, 5, CMAX, 7);                      // extreme horizontal
    send_seg(5, CMAX, 5, CMIN);                      // extreme vertical
    send_seg(-5, -5, CMAX, 6);
    drain();

    // Rectangles: full range, zero-span edges, inverted, random
    write_rect(CMIN, CMAX, CMIN, CMAX);
    random_phase(120);
    write_rect(5000, 5000, -3000, -3000);
    send_seg(4000, -3000, 6000, -3000);              // zero span in Y
    send_seg(5000, -4000, 5000, -2000);              // zero span in X
    random_phase(140);
    write_rect(200000, -200000, 300, -300);
    random_phase(140);
    write_rect(-1000000, 1000000, -20000, 900000);
    random_phase(160);
    for (int p = 0; p < 2; p++) begin
      a = longint'(coord_t'($urandom));
      b = longint'(coord_t'($urandom));
      write_rect(a < b ? a : b, a < b ? b : a, -a / 2, a / 3);
      random_phase(135);
    end
    write_rect(X_LOW_RST, X_HIGH_RST, Y_LOW_RST, Y_HIGH_RST);
    random_phase(100);

    repeat (LATENCY + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("rect_line_clipper verification clean");
    end else begin
      $display("rect_line_clipper verification failed");
    end
    $finish;
  end
endmodule
